// File: design/arm_forward_kinematics_assert.svh
// Assertion macros shared by the arm forward kinematics RTL.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef ARM_FORWARD_KINEMATICS_ASSERT_SVH
`define ARM_FORWARD_KINEMATICS_ASSERT_SVH
`ifndef ASSERT_OFF
`define AFK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define AFK_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define AFK_ASSERT(lbl, prop, msg)
`define AFK_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// File: design/afk_pkg.sv
// Package for the arm forward kinematics block: request types, register codes,
// CORDIC constants and fixed-point rounding helpers. Depends on nothing.
`default_nettype none
package afk_pkg;

    localparam int TRIG_STAGES = 16;
    localparam int MAX_STAGES  = 24;
    localparam int N_STAGES    = (TRIG_STAGES > MAX_STAGES) ? MAX_STAGES : TRIG_STAGES;
    localparam int MERGE_LAT   = 7;
    localparam int LANE_LAT    = N_STAGES + 2;
    localparam int TOTAL_LAT   = LANE_LAT + MERGE_LAT;

    localparam int WW = 34; // internal fixed-point word

    localparam logic signed [WW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [WW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [WW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    localparam logic signed [19:0] OUT_MAX = 20'sd524287;
    localparam logic signed [19:0] OUT_MIN = -20'sd524288;

    typedef enum logic [3:0] {
        REG_BASE_HEIGHT  = 4'd0,
        REG_LINK1_LENGTH = 4'd1,
        REG_LINK2_LENGTH = 4'd2,
        REG_LINK3_LENGTH = 4'd3,
        REG_OFFSET1_Y    = 4'd4,
        REG_OFFSET2_Y    = 4'd5,
        REG_OFFSET3_Y    = 4'd6,
        REG_OFFSET3_Z    = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [14:0] base_height;
        logic signed [14:0] link1_length;
        logic signed [14:0] link2_length;
        logic signed [14:0] link3_length;
        logic signed [14:0] offset1_y;
        logic signed [14:0] offset2_y;
        logic signed [14:0] offset3_y;
        logic signed [14:0] offset3_z;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        base_height:  15'sd4096,
        link1_length: 15'sd3277,
        link2_length: 15'sd3277,
        link3_length: 15'sd2458,
        offset1_y:    -15'sd655,
        offset2_y:    15'sd655,
        offset3_y:    -15'sd655,
        offset3_z:    -15'sd655
    };

    typedef struct packed {
        logic signed [15:0] joint0_angle;
        logic signed [15:0] joint1_angle;
        logic signed [15:0] joint2_angle;
        logic signed [15:0] joint3_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [19:0] tip_x;
        logic signed [19:0] tip_y;
        logic signed [19:0] tip_z;
    } t_out_item;

    typedef struct packed {
        logic signed [WW-1:0] sin_v;
        logic signed [WW-1:0] cos_v;
    } t_trig;

    // Arctangent of 2^-i in Q.30 radians.
    function automatic logic signed [WW-1:0] atan_q30(input int i);
        logic signed [WW-1:0] v;
        case (i)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097141;
            10: v = 34'sd1048574;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q.14 register value widened to a Q.28 position.
    function automatic logic signed [WW-1:0] reg_to_pos(input logic signed [14:0] r);
        logic signed [WW-1:0] w;
        w = WW'(r);
        return w <<< 14;
    endfunction

    // Rounds a Q.58 product sum back to Q.28.
    function automatic logic signed [WW-1:0] rnd30(input logic signed [69:0] v);
        logic signed [69:0] s;
        s = (v + 70'sd536870912) >>> 30;
        return s[WW-1:0];
    endfunction

    // Rounds a Q.28 position to Q.14 and clamps it to the output range.
    function automatic logic signed [19:0] to_out(input logic signed [WW-1:0] v);
        logic signed [WW:0] s;
        s = ((WW+1)'(v) + 35'sd8192) >>> 14;
        if (s > 35'(OUT_MAX)) begin
            return OUT_MAX;
        end else if (s < 35'(OUT_MIN)) begin
            return OUT_MIN;
        end
        return s[19:0];
    endfunction

endpackage
`default_nettype wire

// File: design/afk_cordic_lane.sv
// One pipelined rotation-mode CORDIC lane: a Q2.13 angle in, Q.30 sine and cosine out.
// Depends on afk_pkg.
`default_nettype none
module afk_cordic_lane (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire logic signed [15:0]  i_angle,
    output afk_pkg::t_trig           o_trig
);
    localparam int N  = afk_pkg::N_STAGES;
    localparam int WW = afk_pkg::WW;

    logic signed [WW-1:0] r_x [0:N];
    logic signed [WW-1:0] r_y [0:N];
    logic signed [WW-1:0] r_z [0:N];
    logic                 r_flip [0:N];
    afk_pkg::t_trig       r_trig;

    logic signed [WW-1:0] z_in;
    logic signed [WW-1:0] n_z0;
    logic                 n_flip0;

    // Fold the angle into the half-pi range; the fold flips both results.
    always_comb begin
        z_in = WW'(i_angle) <<< 17;
        n_z0 = z_in;
        n_flip0 = 1'b0;
        if (z_in > afk_pkg::HALF_PI_Q30) begin
            n_z0 = z_in - afk_pkg::PI_Q30;
            n_flip0 = 1'b1;
        end else if (z_in < -afk_pkg::HALF_PI_Q30) begin
            n_z0 = z_in + afk_pkg::PI_Q30;
            n_flip0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= afk_pkg::CORDIC_GAIN;
            r_y[0]    <= '0;
            r_z[0]    <= n_z0;
            r_flip[0] <= n_flip0;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flip[i+1] <= r_flip[i];
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - afk_pkg::atan_q30(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + afk_pkg::atan_q30(i);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_trig.sin_v <= r_flip[N] ? -r_y[N] : r_y[N];
            r_trig.cos_v <= r_flip[N] ? -r_x[N] : r_x[N];
        end
    end

    // The residual angle of the last stage is not needed further.
    assign o_trig = r_trig;
endmodule
`default_nettype wire

// File: design/afk_merge.sv
// Merging stage: chains the elbow, shoulder and base rotations onto the tool offset.
// Depends on afk_pkg; takes the three lane results together.
`default_nettype none
module afk_merge (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  afk_pkg::t_trig          i_trig0,
    input  afk_pkg::t_trig          i_trig1,
    input  afk_pkg::t_trig          i_trig2,
    input  afk_pkg::t_cfg           i_cfg,
    output afk_pkg::t_out_item      o_data
);
    localparam int WW = afk_pkg::WW;

    logic signed [2*WW-1:0] r_a_m0, r_a_m1, r_a_m2, r_a_m3;
    logic signed [WW-1:0]   r_b_x, r_b_y, r_b_z;
    logic signed [2*WW-1:0] r_c_m0, r_c_m1, r_c_m2, r_c_m3;
    logic signed [WW-1:0]   r_c_y;
    logic signed [WW-1:0]   r_d_x, r_d_y, r_d_z;
    logic signed [2*WW-1:0] r_e_m0, r_e_m1, r_e_m2, r_e_m3;
    logic signed [WW-1:0]   r_e_z;
    logic signed [WW-1:0]   r_f_x, r_f_y, r_f_z;
    afk_pkg::t_trig         r_a_t0, r_a_t1, r_b_t0, r_b_t1, r_c_t0, r_d_t0;
    afk_pkg::t_out_item     r_out;

    logic signed [WW-1:0] px0, py0, pz0;

    always_comb begin
        px0 = afk_pkg::reg_to_pos(i_cfg.link3_length);
        py0 = afk_pkg::reg_to_pos(i_cfg.offset3_y);
        pz0 = afk_pkg::reg_to_pos(i_cfg.offset3_z);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Elbow rotation about y.
            r_a_m0 <= i_trig2.cos_v * px0;
            r_a_m1 <= i_trig2.sin_v * pz0;
            r_a_m2 <= i_trig2.cos_v * pz0;
            r_a_m3 <= i_trig2.sin_v * px0;
            r_a_t0 <= i_trig0;
            r_a_t1 <= i_trig1;

            r_b_x  <= afk_pkg::rnd30(70'(r_a_m0) + 70'(r_a_m1))
                      + afk_pkg::reg_to_pos(i_cfg.link2_length);
            r_b_z  <= afk_pkg::rnd30(70'(r_a_m2) - 70'(r_a_m3));
            r_b_y  <= py0 + afk_pkg::reg_to_pos(i_cfg.offset2_y);
            r_b_t0 <= r_a_t0;
            r_b_t1 <= r_a_t1;

            // Shoulder rotation about y.
            r_c_m0 <= r_b_t1.cos_v * r_b_x;
            r_c_m1 <= r_b_t1.sin_v * r_b_z;
            r_c_m2 <= r_b_t1.cos_v * r_b_z;
            r_c_m3 <= r_b_t1.sin_v * r_b_x;
            r_c_y  <= r_b_y;
            r_c_t0 <= r_b_t0;

            r_d_x  <= afk_pkg::rnd30(70'(r_c_m0) + 70'(r_c_m1))
                      + afk_pkg::reg_to_pos(i_cfg.link1_length);
            r_d_z  <= afk_pkg::rnd30(70'(r_c_m2) - 70'(r_c_m3));
            r_d_y  <= r_c_y + afk_pkg::reg_to_pos(i_cfg.offset1_y);
            r_d_t0 <= r_c_t0;

            // Base rotation about z.
            r_e_m0 <= r_d_t0.cos_v * r_d_x;
            r_e_m1 <= r_d_t0.sin_v * r_d_y;
            r_e_m2 <= r_d_t0.sin_v * r_d_x;
            r_e_m3 <= r_d_t0.cos_v * r_d_y;
            r_e_z  <= r_d_z;

            r_f_x  <= afk_pkg::rnd30(70'(r_e_m0) - 70'(r_e_m1));
            r_f_y  <= afk_pkg::rnd30(70'(r_e_m2) + 70'(r_e_m3));
            r_f_z  <= r_e_z + afk_pkg::reg_to_pos(i_cfg.base_height);

            r_out.tip_x <= afk_pkg::to_out(r_f_x);
            r_out.tip_y <= afk_pkg::to_out(r_f_y);
            r_out.tip_z <= afk_pkg::to_out(r_f_z);
        end
    end

    assign o_data = r_out;
endmodule
`default_nettype wire

// File: design/arm_forward_kinematics.sv
// Top level of the arm forward kinematics block: request channels, register file,
// valid pipeline. Depends on afk_pkg, afk_cordic_lane, afk_merge and the assert header.
//
//   channel   direction   handshake             payload
//   in        input       i_in_valid/o_in_stall  i_in_data  (four joint angles)
//   out       output      o_out_valid/i_out_stall o_out_data (tip x, y, z)
//   cfg       input       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One request is accepted every cycle while the pipeline advances; each result goes
// through the CORDIC lanes and then through the merging multiplier chain.
// The whole pipeline advances together and freezes only while a finished result
// sits in the output register and the receiver stalls it.
// Reset is synchronous and active low; it empties the pipeline and loads the
// default arm geometry into the registers.
`default_nettype none
`include "arm_forward_kinematics_assert.svh"
module arm_forward_kinematics (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  afk_pkg::t_in_item       i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output afk_pkg::t_out_item      o_out_data,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [3:0]         i_cfg_index,
    input  wire logic signed [14:0] i_cfg_data
);
    localparam int LAT = afk_pkg::TOTAL_LAT;

    afk_pkg::t_cfg  r_cfg;
    logic [LAT-1:0] r_vld;
    logic           en;
    afk_pkg::t_trig trig0, trig1, trig2;

    // The pipeline moves whenever the output register is empty or being taken.
    assign en          = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[LAT-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // Register writes beyond the eight defined indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= afk_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (afk_pkg::t_reg_idx'(i_cfg_index))
                afk_pkg::REG_BASE_HEIGHT:  r_cfg.base_height  <= i_cfg_data;
                afk_pkg::REG_LINK1_LENGTH: r_cfg.link1_length <= i_cfg_data;
                afk_pkg::REG_LINK2_LENGTH: r_cfg.link2_length <= i_cfg_data;
                afk_pkg::REG_LINK3_LENGTH: r_cfg.link3_length <= i_cfg_data;
                afk_pkg::REG_OFFSET1_Y:    r_cfg.offset1_y    <= i_cfg_data;
                afk_pkg::REG_OFFSET2_Y:    r_cfg.offset2_y    <= i_cfg_data;
                afk_pkg::REG_OFFSET3_Y:    r_cfg.offset3_y    <= i_cfg_data;
                afk_pkg::REG_OFFSET3_Z:    r_cfg.offset3_z    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Three lanes work on the base, shoulder and elbow angles side by side. The
    // wrist angle turns the tool about its own origin and never moves the tip.
    afk_cordic_lane u_lane0 (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_in_data.joint0_angle),
        .o_trig  (trig0)
    );

    afk_cordic_lane u_lane1 (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_in_data.joint1_angle),
        .o_trig  (trig1)
    );

    afk_cordic_lane u_lane2 (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_in_data.joint2_angle),
        .o_trig  (trig2)
    );

    // The merging stage applies elbow, then shoulder, then base to the tool offset.
    afk_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_trig0 (trig0),
        .i_trig1 (trig1),
        .i_trig2 (trig2),
        .i_cfg   (r_cfg),
        .o_data  (o_out_data)
    );

    `AFK_ASSERT(a_stall_needs_result, o_in_stall |-> o_out_valid, "input stalled with no result")
    `AFK_ASSERT(a_advance, en |=> (r_vld[LAT-1] == $past(r_vld[LAT-2])), "valid pipe skipped")
    `AFK_ASSERT(a_freeze, !en |=> $stable(r_vld), "valid pipe moved while frozen")
    `AFK_ASSERT_RST(a_reset_empty, !i_rst_n |=> !o_out_valid, "result right after reset")
endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for arm_forward_kinematics: drives joint-angle requests,
// predicts tool-tip positions with a CORDIC-based model, and checks every result.
// Depends on afk_pkg and the arm_forward_kinematics RTL.
`timescale 1ns / 100ps
module tb_top;

    // Predictor constants, kept locally at the block's arithmetic.
    localparam int NSTG = afk_pkg::N_STAGES;
    localparam longint GAIN = 64'sd652032874;
    localparam longint PI30 = 64'sd3373259426;
    localparam longint HPI30 = 64'sd1686629713;
    localparam int WD_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;
    localparam int N_DIRECTED = 20;
    localparam int N_RANDOM = 750;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    afk_pkg::t_in_item i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    afk_pkg::t_out_item o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [3:0] i_cfg_index = '0;
    logic signed [14:0] i_cfg_data = '0;

    arm_forward_kinematics u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The predictor's own copy of the arm geometry.
    afk_pkg::t_cfg geom;
    // Expected tip positions, oldest first.
    afk_pkg::t_out_item tip_queue[$];
    int n_errors = 0;
    int idle_cycles = 0;
    bit stall_enable = 1'b1;

    // A directed row: joint angles plus, where it is obvious, the expected tip.
    typedef struct {
        afk_pkg::t_in_item angles;
        bit has_tip;
        afk_pkg::t_out_item tip;
    } t_row;

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint arctan_q30(int i);
        longint tab[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097141, 1048574,
                            524288, 262144, 131072, 65536, 32768, 16384, 8192,
                            4096, 2048, 1024, 512, 256, 128};
        return tab[i];
    endfunction

    // Sine and cosine in Q.30 of a Q2.13 angle, by rotation-mode CORDIC.
    task automatic sin_cos(input logic signed [15:0] ang, output longint sn,
                           output longint cs);
        longint z, x, y, nx;
        bit flip;
        z = longint'(ang) * 131072;
        x = GAIN;
        y = 0;
        flip = 1'b0;
        if (z > HPI30) begin
            z -= PI30;
            flip = 1'b1;
        end else if (z < -HPI30) begin
            z += PI30;
            flip = 1'b1;
        end
        for (int i = 0; i < NSTG; i++) begin
            if (z >= 0) begin
                nx = x - shr(y, i);
                y = y + shr(x, i);
                z -= arctan_q30(i);
            end else begin
                nx = x + shr(y, i);
                y = y - shr(x, i);
                z += arctan_q30(i);
            end
            x = nx;
        end
        sn = flip ? -y : y;
        cs = flip ? -x : x;
    endtask

    // Products of Q.28 positions and Q.30 trig values need more than 64 bits.
    function automatic longint round_q58(logic signed [127:0] v);
        logic signed [127:0] r;
        r = (v + 128'sd536870912) >>> 30;
        return longint'(r);
    endfunction

    function automatic logic signed [127:0] mul(longint a, longint b);
        return 128'(a) * 128'(b);
    endfunction

    function automatic logic signed [19:0] to_tip(longint v);
        longint r;
        r = (v + 8192) >>> 14;
        if (r > 524287) r = 524287;
        if (r < -524288) r = -524288;
        return r[19:0];
    endfunction

    // Elbow-first chain of transforms; the wrist angle does not move the tip.
    task automatic predict_tip(input afk_pkg::t_in_item a, output afk_pkg::t_out_item t);
        longint px, py, pz, s, c, nx, nz;
        px = longint'(geom.link3_length) * 16384;
        py = longint'(geom.offset3_y) * 16384;
        pz = longint'(geom.offset3_z) * 16384;
        sin_cos(a.joint2_angle, s, c);
        nx = round_q58(mul(c, px) + mul(s, pz));
        nz = round_q58(mul(c, pz) - mul(s, px));
        px = nx + longint'(geom.link2_length) * 16384;
        py = py + longint'(geom.offset2_y) * 16384;
        pz = nz;
        sin_cos(a.joint1_angle, s, c);
        nx = round_q58(mul(c, px) + mul(s, pz));
        nz = round_q58(mul(c, pz) - mul(s, px));
        px = nx + longint'(geom.link1_length) * 16384;
        py = py + longint'(geom.offset1_y) * 16384;
        pz = nz;
        sin_cos(a.joint0_angle, s, c);
        nx = round_q58(mul(c, px) - mul(s, py));
        t.tip_y = to_tip(round_q58(mul(s, px) + mul(c, py)));
        t.tip_x = to_tip(nx);
        t.tip_z = to_tip(pz + longint'(geom.base_height) * 16384);
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        n_errors++;
    endtask

    // Gap length: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic signed [15:0] rand_angle();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom);
        return 16'($urandom_range(0, 51472) - 25736);
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tip_queue.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                afk_pkg::t_out_item e;
                e = tip_queue.pop_front();
                if (o_out_data.tip_x !== e.tip_x)
                    report_mismatch($sformatf("tip_x %0d, expected %0d",
                                              o_out_data.tip_x, e.tip_x));
                if (o_out_data.tip_y !== e.tip_y)
                    report_mismatch($sformatf("tip_y %0d, expected %0d",
                                              o_out_data.tip_y, e.tip_y));
                if (o_out_data.tip_z !== e.tip_z)
                    report_mismatch($sformatf("tip_z %0d, expected %0d",
                                              o_out_data.tip_z, e.tip_z));
            end
        end
    end

    // Receiver: stall windows of random length, off during some stretches.
    initial begin
        int n;
        forever begin
            n = stall_enable ? gap_len() : 0;
            if (n > 0) begin
                @(posedge i_clk) i_out_stall <= 1'b1;
                repeat (n - 1) @(posedge i_clk);
            end
            @(posedge i_clk) i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Watchdog: cycles in which neither a request, a result nor a register write moves.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sends one request, holding it until accepted; the directed or predicted tip is queued.
    // Called at a rising edge; valid stays high after acceptance so that the
    // next request can follow in the very next cycle.
    task automatic send_request(input afk_pkg::t_in_item a, input bit has_tip,
                                input afk_pkg::t_out_item tip);
        afk_pkg::t_out_item p;
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= a;
        predict_tip(a, p);
        if (has_tip && p !== tip)
            report_mismatch("predictor disagrees with directed row");
        tip_queue.push_back(has_tip ? tip : p);
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_reg(input afk_pkg::t_reg_idx idx, input logic signed [14:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            afk_pkg::REG_BASE_HEIGHT:  geom.base_height = val;
            afk_pkg::REG_LINK1_LENGTH: geom.link1_length = val;
            afk_pkg::REG_LINK2_LENGTH: geom.link2_length = val;
            afk_pkg::REG_LINK3_LENGTH: geom.link3_length = val;
            afk_pkg::REG_OFFSET1_Y:    geom.offset1_y = val;
            afk_pkg::REG_OFFSET2_Y:    geom.offset2_y = val;
            afk_pkg::REG_OFFSET3_Y:    geom.offset3_y = val;
            afk_pkg::REG_OFFSET3_Z:    geom.offset3_z = val;
            default: ;
        endcase
    endtask

    // Drops valid, waits until every queued tip has come back, then lets the
    // pipe drain.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (tip_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_all(input logic signed [14:0] v[8]);
        for (int i = 0; i < 8; i++) write_reg(afk_pkg::t_reg_idx'(i), v[i]);
    endtask

    initial begin
        t_row rows[N_DIRECTED];
        afk_pkg::t_in_item a;
        afk_pkg::t_out_item none;
        logic signed [14:0] v[8];
        none = '0;
        geom = afk_pkg::CFG_RESET;

        // Directed table. With all joints at zero the reset arm lies along x:
        // x = 3277+3277+2458, y = -655+655-655, z = 4096-655 (within CORDIC error,
        // so the predictor gives the exact value for the rest).
        for (int i = 0; i < N_DIRECTED; i++) begin
            rows[i].has_tip = 1'b0;
            rows[i].tip = '0;
        end
        rows[0].angles = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
        rows[0].has_tip = 1'b1;
        rows[0].tip = '{20'sd9012, -20'sd655, 20'sd3441};
        rows[1].angles = '{16'sd25736, 16'sd0, 16'sd0, 16'sd0};
        rows[2].angles = '{-16'sd25736, 16'sd0, 16'sd0, 16'sd0};
        rows[3].angles = '{16'sd0, 16'sd25736, 16'sd0, 16'sd0};
        rows[4].angles = '{16'sd0, -16'sd25736, 16'sd0, 16'sd0};
        rows[5].angles = '{16'sd0, 16'sd0, 16'sd25736, 16'sd0};
        rows[6].angles = '{16'sd0, 16'sd0, -16'sd25736, 16'sd0};
        // The wrist angle has no effect on the tip.
        rows[7].angles = '{16'sd0, 16'sd0, 16'sd0, 16'sd25736};
        rows[7].has_tip = 1'b1;
        rows[7].tip = rows[0].tip;
        rows[8].angles = '{16'sd0, 16'sd0, 16'sd0, -16'sd32768};
        rows[8].has_tip = 1'b1;
        rows[8].tip = rows[0].tip;
        // Patterns beyond pi and around the half-pi fold.
        rows[9].angles = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        rows[10].angles = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
        rows[11].angles = '{16'sd12868, 16'sd12869, -16'sd12868, 16'sd0};
        rows[12].angles = '{-16'sd12869, 16'sd12868, 16'sd12869, 16'sd0};
        rows[13].angles = '{16'sd6434, 16'sd6434, 16'sd6434, 16'sd6434};
        rows[14].angles = '{16'sd1, -16'sd1, 16'sd1, -16'sd1};
        rows[15].angles = '{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa};
        rows[16].angles = '{16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555};
        rows[17].angles = '{16'sd25735, -16'sd25735, 16'sd25735, 16'sd0};
        rows[18].angles = '{16'sd100, 16'sd200, 16'sd300, 16'sd400};
        rows[19].angles = '{-16'sd20000, 16'sd15000, -16'sd9000, 16'sd3};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(rows[i].angles, rows[i].has_tip, rows[i].tip);
        wait_idle();

        // Geometry phases: extremes first, then the reset geometry, then random values.
        for (int ph = 0; ph < 6; ph++) begin
            for (int i = 0; i < 8; i++) begin
                case (ph)
                    0: v[i] = 15'sd16383;
                    1: v[i] = -15'sd16384;
                    2: v[i] = (i % 2) ? 15'sd16383 : -15'sd16384;
                    3: v[i] = afk_pkg::CFG_RESET[(7 - i) * 15 +: 15];
                    default: v[i] = 15'($urandom);
                endcase
            end
            write_all(v);
            // A write to an index beyond the eight is ignored.
            if (ph == 1) write_reg(afk_pkg::t_reg_idx'(4'd12), 15'sd1234);
            stall_enable = (ph != 2);
            for (int k = 0; k < N_RANDOM / 6; k++) begin
                a.joint0_angle = rand_angle();
                a.joint1_angle = rand_angle();
                a.joint2_angle = rand_angle();
                a.joint3_angle = rand_angle();
                if (k < 4) begin
                    a.joint0_angle = (k[0]) ? 16'sd25736 : -16'sd25736;
                    a.joint1_angle = (k[1]) ? 16'sd25736 : -16'sd25736;
                end
                send_request(a, 1'b0, none);
            end
            wait_idle();
            stall_enable = 1'b1;
        end

        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
